/* src/ps2_scancode_to_key_translator_defines.svh */
// Assertion macros shared by the checker files of the scan code translator.
`ifndef PS2_SCANCODE_TO_KEY_TRANSLATOR_DEFINES_SVH
`define PS2_SCANCODE_TO_KEY_TRANSLATOR_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define PS2KT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define PS2KT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* src/ps2kt_pkg.sv */
package ps2kt_pkg;

  localparam logic [7:0] PfxExt0  = 8'hE0;
  localparam logic [7:0] PfxExt1  = 8'hE1;
  localparam logic [7:0] PfxRel   = 8'hF0;
  localparam logic [7:0] LastCode = 8'h87;
  localparam int unsigned TabDepth = 136;

  localparam logic [7:0] KcNo    = 8'hFF;
  localparam logic [7:0] KcShift = 8'hE0;
  localparam logic [7:0] KcBreak = 8'hE1;
  localparam logic [7:0] KcCtrl  = 8'hE2;
  localparam logic [7:0] KcLatin = 8'hE3;
  localparam logic [2:0] KcFnType = 3'b110;
  localparam logic [4:0] CtrlMask = 5'h1F;

  localparam logic [7:0] PLAIN_TAB [TabDepth] = '{
    8'hFF, 8'hC9, 8'hFF, 8'hC5, 8'hC3, 8'hC1, 8'hC2, 8'hCC,
    8'hFF, 8'hCA, 8'hC8, 8'hC6, 8'hC4, 8'h09, 8'h60, 8'hFF,
    8'hFF, 8'hE3, 8'hE0, 8'hE0, 8'hE2, 8'h71, 8'h31, 8'hFF,
    8'hFF, 8'hE0, 8'h7A, 8'h73, 8'h61, 8'h77, 8'h32, 8'hFF,
    8'hFF, 8'h63, 8'h78, 8'h64, 8'h65, 8'h34, 8'h33, 8'hFF,
    8'hFF, 8'h20, 8'h76, 8'h66, 8'h74, 8'h72, 8'h35, 8'hFF,
    8'hFF, 8'h6E, 8'h62, 8'h68, 8'h67, 8'h79, 8'h36, 8'hFF,
    8'hFF, 8'h80, 8'h6D, 8'h6A, 8'h75, 8'h37, 8'h38, 8'hFF,
    8'hFF, 8'h2C, 8'h6B, 8'h69, 8'h6F, 8'h30, 8'h39, 8'hFF,
    8'hFF, 8'h2E, 8'h2F, 8'h6C, 8'h3B, 8'h70, 8'h2D, 8'hFF,
    8'hFF, 8'hFF, 8'h27, 8'hFF, 8'h5B, 8'h3D, 8'hFF, 8'h0D,
    8'hE3, 8'hE0, 8'h0A, 8'h5D, 8'h5C, 8'hFF, 8'hFF, 8'hE1,
    8'h80, 8'h80, 8'hE1, 8'hE0, 8'h7F, 8'hFF, 8'h08, 8'hFF,
    8'hFF, 8'h31, 8'h80, 8'h34, 8'h37, 8'h2C, 8'hFF, 8'hFF,
    8'h30, 8'h2E, 8'h32, 8'h35, 8'h36, 8'h38, 8'h1B, 8'hFF,
    8'hCB, 8'h0A, 8'h33, 8'hFF, 8'hFF, 8'h39, 8'hFF, 8'hFF,
    8'hFF, 8'hFF, 8'hFF, 8'hC7, 8'h2D, 8'hFF, 8'hFF, 8'hFF
  };

  localparam logic [7:0] SHIFT_TAB [TabDepth] = '{
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hC1,
    8'h1B, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h09, 8'h7E, 8'hC2,
    8'hFF, 8'hE2, 8'hE0, 8'hE0, 8'hE0, 8'h51, 8'h21, 8'hC3,
    8'hFF, 8'hE0, 8'h5A, 8'h53, 8'h41, 8'h57, 8'h40, 8'hC4,
    8'hFF, 8'h43, 8'h58, 8'h44, 8'h45, 8'h24, 8'h23, 8'hC5,
    8'hFF, 8'h20, 8'h56, 8'h46, 8'h54, 8'h52, 8'h25, 8'hC6,
    8'hFF, 8'h4E, 8'h42, 8'h48, 8'h47, 8'h59, 8'h5E, 8'hC7,
    8'hFF, 8'h80, 8'h4D, 8'h4A, 8'h55, 8'h26, 8'h2A, 8'hC8,
    8'hFF, 8'h3C, 8'h4B, 8'h49, 8'h4F, 8'h29, 8'h28, 8'hC9,
    8'hFF, 8'h3E, 8'h3F, 8'h4C, 8'h3A, 8'h50, 8'h5F, 8'hCA,
    8'hFF, 8'hFF, 8'h22, 8'hFF, 8'h7B, 8'h2B, 8'hCB, 8'h0D,
    8'hE3, 8'hE0, 8'h0A, 8'h7D, 8'h7C, 8'hFF, 8'hCC, 8'hE1,
    8'h80, 8'h80, 8'hE1, 8'hE0, 8'h7F, 8'hFF, 8'h08, 8'hFF,
    8'hFF, 8'h31, 8'h80, 8'h34, 8'h37, 8'h2C, 8'hFF, 8'hFF,
    8'h30, 8'h2E, 8'h32, 8'h35, 8'h36, 8'h38, 8'hA1, 8'hA2,
    8'hFF, 8'h0A, 8'h33, 8'hFF, 8'hA4, 8'h39, 8'hA3, 8'hFF,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h2D, 8'hFF, 8'hFF, 8'hFF
  };

  // Codes past the end of the tables read as unmapped.
  function automatic logic [7:0] plain_key(logic [7:0] code);
    logic [7:0] key;
    if (code > LastCode) begin
      key = KcNo;
    end else begin
      key = PLAIN_TAB[code];
    end
    return key;
  endfunction

  function automatic logic [7:0] shift_key(logic [7:0] code);
    logic [7:0] key;
    if (code > LastCode) begin
      key = KcNo;
    end else begin
      key = SHIFT_TAB[code];
    end
    return key;
  endfunction

endpackage

/* src/ps2_scancode_to_key_translator.sv */
// PS/2 scan code set 2 to key code translator: one raw scan code byte goes in
// per transaction and at most one key code comes out. When the result register
// is free, the accepted byte sits in the input register and its decoded key
// code is written to the result register and presented. A new byte can be
// taken in every cycle unless a held code that emits a key finds the result
// register full and not being drained; the rate is set by the table lookups
// and flag update between the input and result registers. Prefixes E0/E1
// mark the next code as extended (dropped), F0 marks it as a release (only
// Shift and Ctrl releases matter, and nothing is emitted). Function keys,
// Break, the Latin key, unmapped codes and codes above 0x87 give no result.
// While Ctrl is held, plain characters come out masked to five bits. Values
// of 0x80 and above on key_code_o are special keys (view, keypad functions).
module ps2_scancode_to_key_translator (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       scan_code_valid_i,
  output logic       scan_code_ready_o,
  input  logic [7:0] scan_code_i,
  output logic       key_code_valid_o,
  input  logic       key_code_ready_i,
  output logic [7:0] key_code_o
);

  // Input register: holds one accepted scan code until it is processed.
  logic       in_valid_q;
  logic [7:0] in_code_q;

  // Keyboard state flags.
  logic shift_q, shift_d;
  logic ctrl_q, ctrl_d;
  logic ext_q, ext_d;
  logic rel_q, rel_d;

  // Result register.
  logic       out_valid_q;
  logic [7:0] out_key_q;

  logic       emit;
  logic [7:0] emit_key;
  logic [7:0] look_key;
  logic [7:0] rel_key;
  logic       out_free;
  logic       advance;
  logic       in_accept;

  // The result register is free when empty or being drained this cycle.
  assign out_free  = !out_valid_q || key_code_ready_i;
  // Advance the held code unless it produces a key with nowhere to go.
  assign advance   = in_valid_q && (!emit || out_free);
  assign scan_code_ready_o = !in_valid_q || advance;
  assign in_accept = scan_code_valid_i && scan_code_ready_o;

  assign look_key = shift_q ? ps2kt_pkg::shift_key(in_code_q)
                            : ps2kt_pkg::plain_key(in_code_q);
  assign rel_key  = ps2kt_pkg::plain_key(in_code_q);

  // Decode one scan code against the current flags.
  always_comb begin
    shift_d  = shift_q;
    ctrl_d   = ctrl_q;
    ext_d    = ext_q;
    rel_d    = rel_q;
    emit     = 1'b0;
    emit_key = look_key;
    if (in_code_q == ps2kt_pkg::PfxExt0 || in_code_q == ps2kt_pkg::PfxExt1) begin
      // Extended prefix wins even over a pending release.
      ext_d = 1'b1;
    end else if (rel_q) begin
      // Release: only modifier keys change state.
      if (rel_key == ps2kt_pkg::KcCtrl) begin
        ctrl_d = 1'b0;
      end else if (rel_key == ps2kt_pkg::KcShift) begin
        shift_d = 1'b0;
      end
      ext_d = 1'b0;
      rel_d = 1'b0;
    end else if (in_code_q == ps2kt_pkg::PfxRel) begin
      rel_d = 1'b1;
    end else if (in_code_q > ps2kt_pkg::LastCode) begin
      // Out of table range: drop, state untouched.
    end else if (ext_q) begin
      // Drop the code that follows an extended prefix.
      ext_d = 1'b0;
    end else if (!look_key[7]) begin
      emit = 1'b1;
      if (ctrl_q) begin
        emit_key = {3'b000, look_key[4:0] & ps2kt_pkg::CtrlMask};
      end
    end else if (look_key[7:5] == ps2kt_pkg::KcFnType) begin
      // Function keys give nothing.
    end else begin
      case (look_key)
        ps2kt_pkg::KcShift: shift_d = 1'b1;
        ps2kt_pkg::KcCtrl:  ctrl_d  = 1'b1;
        ps2kt_pkg::KcBreak,
        ps2kt_pkg::KcLatin,
        ps2kt_pkg::KcNo:    emit    = 1'b0;
        default:            emit    = 1'b1;
      endcase
    end
  end

  // Control state: input valid, flags and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      shift_q     <= 1'b0;
      ctrl_q      <= 1'b0;
      ext_q       <= 1'b0;
      rel_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        shift_q <= shift_d;
        ctrl_q  <= ctrl_d;
        ext_q   <= ext_d;
        rel_q   <= rel_d;
      end
      if (advance && emit) begin
        out_valid_q <= 1'b1;
      end else if (key_code_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_code_q <= scan_code_i;
    end
    if (advance && emit) begin
      out_key_q <= emit_key;
    end
  end

  assign key_code_valid_o = out_valid_q;
  assign key_code_o       = out_key_q;

endmodule

/* src/ps2kt_sva_checker.sv */
`include "ps2_scancode_to_key_translator_defines.svh"

module ps2kt_sva_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       scan_code_valid_i,
  input logic       scan_code_ready_o,
  input logic [7:0] scan_code_i,
  input logic       key_code_valid_o,
  input logic       key_code_ready_i,
  input logic [7:0] key_code_o
);

  logic unused_code;
  assign unused_code = ^scan_code_i;

  // Hold a stalled result until it is taken.
  `PS2KT_ASSERT(a_out_hold, key_code_valid_o && !key_code_ready_i |=> key_code_valid_o, "result dropped while stalled")
  `PS2KT_ASSERT(a_out_stable, key_code_valid_o && !key_code_ready_i |=> $stable(key_code_o), "stalled result changed")
  // No result leaves while reset is asserted.
  `PS2KT_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> !key_code_valid_o, "result valid in reset")
  // Function, modifier, Break, Latin and unmapped codes never leave the block.
  `PS2KT_ASSERT(a_key_range, key_code_valid_o |-> key_code_o[7:6] != 2'b11, "dropped key code emitted")
  // A fresh result stems from an input transaction that passed through the input register into the result register.
  `PS2KT_ASSERT(a_out_cause, $rose(key_code_valid_o) |-> $past(scan_code_valid_i && scan_code_ready_o, 2), "result without input")

endmodule

bind ps2_scancode_to_key_translator ps2kt_sva_checker u_ps2kt_sva_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .scan_code_valid_i (scan_code_valid_i),
  .scan_code_ready_o (scan_code_ready_o),
  .scan_code_i       (scan_code_i),
  .key_code_valid_o  (key_code_valid_o),
  .key_code_ready_i  (key_code_ready_i),
  .key_code_o        (key_code_o)
);
